// File: hdl/bdmv_pkg.sv
// Shared types and constants of the block-diagonal matrix-vector unit.
`default_nettype none

package bdmv_pkg;

  // Field widths
  localparam int GRID_FW     = 4;
  localparam int IDX_FW      = 5;
  localparam int VAL_W       = 32;
  localparam int ACC_W       = 64;
  localparam int FRAC_BITS   = 16;
  localparam int EQS_CFG_W   = 6;
  localparam int GRID_CFG_W  = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int CNT_W       = 7;
  localparam int GCNT_W      = 9;

  // At most this many row results per trigger
  localparam int RESULT_LIMIT = 32;

  // Item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EQS_IN_USE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_IN_USE = 1'b1;

  typedef logic signed [VAL_W-1:0] value_t;

  // Sequencer to multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic clear;
  } mac_ctl_t;

  // Multiply-accumulate unit back to sequencer
  typedef struct packed {
    logic              busy;
    logic              saturated;
    logic [VAL_W-1:0]  value;
  } mac_res_t;

endpackage

`default_nettype wire

// File: hdl/bdmv_cfg_if.sv
// Configuration write channel of the block-diagonal matrix-vector unit.
`default_nettype none

interface bdmv_cfg_if;
  import bdmv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   reg_index;
  logic [CFG_DATA_W-1:0]  write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

// File: hdl/bdmv_in_if.sv
// Input item channel of the block-diagonal matrix-vector unit.
`default_nettype none

interface bdmv_in_if;
  import bdmv_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [GRID_FW-1:0]  grid_index;
  logic [IDX_FW-1:0]   row_index;
  logic [IDX_FW-1:0]   column_index;
  logic [VAL_W-1:0]    operand_value;
  logic                last_element;

  modport source (output valid, output mode, output grid_index, output row_index,
                  output column_index, output operand_value, output last_element,
                  input ready);
  modport sink   (input valid, input mode, input grid_index, input row_index,
                  input column_index, input operand_value, input last_element,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/bdmv_out_if.sv
// Result channel of the block-diagonal matrix-vector unit.
`default_nettype none

interface bdmv_out_if;
  import bdmv_pkg::*;

  logic                valid;
  logic                ready;
  logic [GRID_FW-1:0]  result_grid;
  logic [IDX_FW-1:0]   result_row;
  logic [VAL_W-1:0]    product_value;
  logic                saturated;
  logic                last_row;

  modport source (output valid, output result_grid, output result_row,
                  output product_value, output saturated, output last_row,
                  input ready);
  modport sink   (input valid, input result_grid, input result_row,
                  input product_value, input saturated, input last_row,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/bdmv_mac.sv
// Shared multiply-accumulate unit: Q16.16 product, floor shift, 64-bit sum, saturation.
`default_nettype none

module bdmv_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  bdmv_pkg::mac_ctl_t ctl,
  input  bdmv_pkg::value_t   op_a,
  input  bdmv_pkg::value_t   op_b,
  output bdmv_pkg::mac_res_t res
);
  import bdmv_pkg::*;

  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] prod_nxt;
  logic                    pv_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  // Form the exact Q32.32 product
  assign prod_nxt = ACC_W'($signed(op_a)) * ACC_W'($signed(op_b));

  // Add the product floored to Q16.16, or clear for the next row
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + (prod_r >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r  <= ctl.valid;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Clamp the sum to the 32-bit range
  always_comb begin
    res.busy      = pv_r;
    res.saturated = 1'b0;
    res.value     = acc_r[VAL_W-1:0];
    if (acc_r > 64'sh0000_0000_7FFF_FFFF) begin
      res.saturated = 1'b1;
      res.value     = 32'h7FFF_FFFF;
    end else if (acc_r < -64'sh0000_0000_8000_0000) begin
      res.saturated = 1'b1;
      res.value     = 32'h8000_0000;
    end
  end

endmodule

`default_nettype wire

// File: hdl/block_diagonal_matvec_unit.sv
// Top level: Jacobian and vector stores, row/column sequencer and result register.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+---------------------------------------------
//  cfg_ch   | in  | valid/ready   | reg_index, write_data (always ready)
//  in_ch    | in  | valid/ready   | mode, grid_index, row_index, column_index,
//           |     |               | operand_value, last_element
//  out_ch   | out | valid/ready   | result_grid, result_row, product_value,
//           |     |               | saturated, last_row
//
// A load word, or a vector word without last_element, starts no product sweep.
// A triggering word starts a sweep over the n rows for n equations: each row
// issues n reads into the one multiply-accumulate unit, then drains the read,
// product and sum registers before the handoff.
// A row waits while the result register is still held by a stalled sink.
// rst_n is synchronous; the stores are not cleared and hold nothing defined.
// in_ch.ready is high only while no product sweep is running.
`default_nettype none

module block_diagonal_matvec_unit #(
  parameter int MAX_EQS  = 32,
  parameter int MAX_GRID = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  bdmv_cfg_if.sink   cfg_ch,
  bdmv_in_if.sink    in_ch,
  bdmv_out_if.source out_ch
);
  import bdmv_pkg::*;

  localparam int EQ_W    = (MAX_EQS > 1) ? $clog2(MAX_EQS) : 1;
  localparam int GRID_W  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int JAC_AW  = GRID_W + 2 * EQ_W;
  localparam int JAC_DEPTH = 1 << JAC_AW;
  localparam int VEC_DEPTH = 1 << EQ_W;
  localparam int EQ_LIM  = (MAX_EQS < RESULT_LIMIT) ? MAX_EQS : RESULT_LIMIT;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  // Configuration registers
  logic [EQS_CFG_W-1:0]  eqs_r;
  logic [GRID_CFG_W-1:0] grid_cfg_r;

  // Sequencer
  logic [1:0]        state_r, state_nxt;
  logic [EQ_W-1:0]   r_r, r_nxt;
  logic [EQ_W-1:0]   c_r, c_nxt;
  logic [EQ_W-1:0]   last_r, last_nxt;
  logic [GRID_W-1:0] grid_r, grid_nxt;
  logic              rd_vld_r, rd_vld_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [GRID_FW-1:0] out_grid_r, out_grid_nxt;
  logic [IDX_FW-1:0]  out_row_r, out_row_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;
  logic               out_sat_r, out_sat_nxt;
  logic               out_last_r, out_last_nxt;

  // Stores
  logic [VAL_W-1:0]  jac_mem [JAC_DEPTH];
  logic [VAL_W-1:0]  vec_mem [VEC_DEPTH];
  logic [VAL_W-1:0]  jac_rd_r;
  logic [VAL_W-1:0]  vec_rd_r;
  logic [JAC_AW-1:0] jac_wa;
  logic [JAC_AW-1:0] jac_ra;
  logic [EQ_W-1:0]   vec_wa;

  logic [CNT_W-1:0]  n_act;
  logic [CNT_W-1:0]  n_m1;
  logic [GCNT_W-1:0] g_act;
  logic              in_take;
  logic              in_ok;
  logic              jac_we;
  logic              vec_we;
  logic              trigger;
  logic              out_free;
  logic              pipe_empty;

  mac_ctl_t mac_ctl;
  mac_res_t mac_res;

  // Write configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eqs_r      <= EQS_CFG_W'(1);
      grid_cfg_r <= GRID_CFG_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_EQS_IN_USE:  eqs_r      <= cfg_ch.write_data[EQS_CFG_W-1:0];
        CFG_GRID_IN_USE: grid_cfg_r <= cfg_ch.write_data[GRID_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the active block size and grid count
  always_comb begin
    n_act = {1'b0, eqs_r};
    if (n_act == '0) begin
      n_act = CNT_W'(1);
    end else if (n_act > CNT_W'(EQ_LIM)) begin
      n_act = CNT_W'(EQ_LIM);
    end
    g_act = {{(GCNT_W-GRID_CFG_W){1'b0}}, grid_cfg_r};
    if (g_act == '0) begin
      g_act = GCNT_W'(1);
    end else if (g_act > GCNT_W'(MAX_GRID)) begin
      g_act = GCNT_W'(MAX_GRID);
    end
  end
  assign n_m1 = n_act - CNT_W'(1);

  // Qualify an incoming word; out-of-range words are dropped
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ok = ({{(GCNT_W-GRID_FW){1'b0}}, in_ch.grid_index} < g_act) &&
                 ({{(CNT_W-IDX_FW){1'b0}}, in_ch.column_index} < n_act) &&
                 ((in_ch.mode == MODE_VECTOR) ||
                  ({{(CNT_W-IDX_FW){1'b0}}, in_ch.row_index} < n_act));
  assign jac_we  = in_take && in_ok && (in_ch.mode == MODE_LOAD);
  assign vec_we  = in_take && in_ok && (in_ch.mode == MODE_VECTOR);
  assign trigger = vec_we && in_ch.last_element;

  assign jac_wa = {GRID_W'(in_ch.grid_index), EQ_W'(in_ch.row_index),
                   EQ_W'(in_ch.column_index)};
  assign vec_wa = EQ_W'(in_ch.column_index);
  assign jac_ra = {grid_r, r_r, c_r};

  // Store and read the Jacobian blocks
  always_ff @(posedge clk) begin
    if (jac_we) begin
      jac_mem[jac_wa] <= in_ch.operand_value;
    end
    jac_rd_r <= jac_mem[jac_ra];
  end

  // Store and read the vector buffer
  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_wa] <= in_ch.operand_value;
    end
    vec_rd_r <= vec_mem[c_r];
  end

  bdmv_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (jac_rd_r),
    .op_b  (vec_rd_r),
    .res   (mac_res)
  );

  assign out_free   = !out_valid_r || out_ch.ready;
  assign pipe_empty = !rd_vld_r && !mac_res.busy;

  // Sequence rows and columns through the shared unit
  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    grid_nxt      = grid_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_grid_nxt  = out_grid_r;
    out_row_nxt   = out_row_r;
    out_val_nxt   = out_val_r;
    out_sat_nxt   = out_sat_r;
    out_last_nxt  = out_last_r;
    mac_ctl.valid = rd_vld_r;
    mac_ctl.clear = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (trigger) begin
          state_nxt = S_RUN;
          r_nxt     = '0;
          c_nxt     = '0;
          last_nxt  = EQ_W'(n_m1);
          grid_nxt  = GRID_W'(in_ch.grid_index);
        end
      end
      S_RUN: begin
        // Issue one column read per cycle
        rd_vld_nxt = 1'b1;
        if (c_r == last_r) begin
          c_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          c_nxt = c_r + EQ_W'(1);
        end
      end
      S_DRAIN: begin
        // Hand the finished row to the result register
        if (pipe_empty && out_free) begin
          out_valid_nxt = 1'b1;
          out_grid_nxt  = GRID_FW'(grid_r);
          out_row_nxt   = IDX_FW'(r_r);
          out_val_nxt   = mac_res.value;
          out_sat_nxt   = mac_res.saturated;
          out_last_nxt  = (r_r == last_r);
          mac_ctl.clear = 1'b1;
          if (r_r == last_r) begin
            state_nxt = S_IDLE;
          end else begin
            r_nxt     = r_r + EQ_W'(1);
            state_nxt = S_RUN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      r_r         <= '0;
      c_r         <= '0;
      last_r      <= '0;
      grid_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      last_r      <= last_nxt;
      grid_r      <= grid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_grid_r <= out_grid_nxt;
    out_row_r  <= out_row_nxt;
    out_val_r  <= out_val_nxt;
    out_sat_r  <= out_sat_nxt;
    out_last_r <= out_last_nxt;
  end

  // Drive the channels
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_grid   = out_grid_r;
  assign out_ch.result_row    = out_row_r;
  assign out_ch.product_value = out_val_r;
  assign out_ch.saturated     = out_sat_r;
  assign out_ch.last_row      = out_last_r;

endmodule

`default_nettype wire
